[rtl/bprp_pkg.sv]
// ----------------------------------------------------------------------------
// bprp_pkg: shared types and constants for the byte pattern replace block
// Item structs, window cell contents, cell control bundle, register indexes.
// ----------------------------------------------------------------------------
package bprp_pkg;

  localparam int DATA_W    = 8;
  localparam int PAT_W     = 64;
  localparam int LEN_W     = 4;
  localparam int CFG_IDX_W = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OLD_PATTERN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OLD_LENGTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NEW_PATTERN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NEW_LENGTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PAD_BYTE    = 3'd4;

  localparam logic [DATA_W-1:0] PAD_RESET = 8'h20;

  // window positions and lengths
  typedef logic [LEN_W-1:0] pos_t;

  typedef struct packed {
    logic [DATA_W-1:0] data_in;
    logic              in_last;
  } in_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] data_out;
    logic              out_last;
    logic              match_start;
    logic              setup_error;
  } out_item_t;

  // contents of one window cell
  typedef struct packed {
    logic [DATA_W-1:0] data_byte;
    logic              locked;
    logic              start;
  } cell_t;

  // control broadcast from the top level to every cell
  typedef struct packed {
    logic              append;
    logic              shift;
    logic              hit;
    logic [DATA_W-1:0] new_byte;
    pos_t              fill;
    pos_t              base;
    pos_t              len;
    pos_t              new_len;
    logic [DATA_W-1:0] pad;
    logic [PAT_W-1:0]  old_pattern;
    logic [PAT_W-1:0]  new_pattern;
  } cell_ctrl_t;

  // byte idx of a packed pattern word, byte 0 in the low bits
  function automatic logic [DATA_W-1:0] pat_byte(input logic [PAT_W-1:0] word,
                                                 input logic [2:0] idx);
    return word[{idx, 3'b000} +: DATA_W];
  endfunction

endpackage

[rtl/byte_pattern_replace_pad_core.sv]
// ----------------------------------------------------------------------------
// byte_pattern_replace_pad_core: streaming fixed-length search and replace
// A byte leaves once len-1 later bytes have entered (len is old_length, or one
// for an invalid setup), then passes through the registered output buffer.
// Throughput is one byte per cycle while no drain is under way and the output
// buffer has room; a buffer's last byte drains the window via cell 0, stalling input.
// Reset is synchronous: window, counters and output buffer clear, registers
// return to their defaults (pad byte 0x20).
// ----------------------------------------------------------------------------
module byte_pattern_replace_pad_core
  import bprp_pkg::*;
#(
  parameter int PATTERN_MAX = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PAT_W-1:0]     cfg_data
);

  localparam int FILL_W = $clog2(PATTERN_MAX + 1);

  logic [PAT_W-1:0]  old_pattern;
  pos_t              old_length;
  logic [PAT_W-1:0]  new_pattern;
  pos_t              new_length;
  logic [DATA_W-1:0] pad_byte;

  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] fill_next;
  logic [FILL_W-1:0] drain;
  logic [FILL_W-1:0] drain_next;
  logic              flush;
  logic              flush_next;

  logic       err;
  pos_t       len;
  pos_t       f1;
  pos_t       base;
  pos_t       emits;
  logic       full_win;
  logic       accept;
  logic       emit_now;
  logic       busy;
  logic       drain_emit;
  logic       emit;
  logic       buf_full;
  logic       hit;
  out_item_t  push_item;
  cell_ctrl_t ctrl;

  cell_t                  r  [PATTERN_MAX];
  cell_t                  up [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] ok;

  // configuration write decode
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      old_pattern <= '0;
      old_length  <= '0;
      new_pattern <= '0;
      new_length  <= '0;
      pad_byte    <= PAD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_OLD_PATTERN: old_pattern <= cfg_data;
        CFG_OLD_LENGTH:  old_length  <= cfg_data[LEN_W-1:0];
        CFG_NEW_PATTERN: new_pattern <= cfg_data;
        CFG_NEW_LENGTH:  new_length  <= cfg_data[LEN_W-1:0];
        CFG_PAD_BYTE:    pad_byte    <= cfg_data[DATA_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // setup check and window geometry for this transfer
  assign err = (old_length == '0) || (old_length > pos_t'(PATTERN_MAX)) ||
               (new_length > old_length);
  assign len      = err ? pos_t'(1) : old_length;
  assign f1       = pos_t'(fill) + pos_t'(1);
  assign full_win = (f1 >= len);
  assign base     = (f1 > len) ? (f1 - len) : '0;
  assign emits    = in_data.in_last ? f1 :
                    (full_win ? (f1 - len + pos_t'(1)) : '0);

  // handshake and emit control
  assign busy       = (drain != '0);
  assign in_stall   = busy || buf_full;
  assign accept     = in_valid && !in_stall;
  assign emit_now   = accept && (in_data.in_last || full_win);
  assign drain_emit = busy && !buf_full;
  assign emit       = emit_now || drain_emit;
  assign hit        = accept && !err && full_win && (&ok);

  // control broadcast to the cells
  always_comb begin
    ctrl.append      = accept;
    ctrl.shift       = emit;
    ctrl.hit         = hit;
    ctrl.new_byte    = in_data.data_in;
    ctrl.fill        = pos_t'(fill);
    ctrl.base        = base;
    ctrl.len         = len;
    ctrl.new_len     = new_length;
    ctrl.pad         = pad_byte;
    ctrl.old_pattern = old_pattern;
    ctrl.new_pattern = new_pattern;
  end

  // window cell chain, cell 0 holds the oldest byte
  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
    if (i == PATTERN_MAX - 1) begin : g_top
      assign up[i] = '0;
    end else begin : g_mid
      assign up[i] = r[i+1];
    end
    bprp_cell #(
      .IDX (i)
    ) u_cell (
      .clk   (clk),
      .rst   (rst),
      .ctrl  (ctrl),
      .up    (up[i]),
      .entry (r[i]),
      .ok    (ok[i])
    );
  end

  // result taken from the window head
  always_comb begin
    push_item.data_out    = r[0].data_byte;
    push_item.match_start = r[0].start;
    push_item.setup_error = err;
    push_item.out_last    = emit_now ? (in_data.in_last && (emits == pos_t'(1)))
                                     : (flush && (drain == FILL_W'(1)));
  end

  // fill and drain counters
  always_comb begin
    fill_next  = fill;
    drain_next = drain;
    flush_next = flush;
    if (accept) begin
      fill_next = FILL_W'(f1 - (emit_now ? pos_t'(1) : pos_t'(0)));
      if (emit_now) begin
        drain_next = FILL_W'(emits - pos_t'(1));
        flush_next = in_data.in_last;
      end
    end else if (drain_emit) begin
      fill_next  = fill - FILL_W'(1);
      drain_next = drain - FILL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill  <= '0;
      drain <= '0;
      flush <= 1'b0;
    end else begin
      fill  <= fill_next;
      drain <= drain_next;
      flush <= flush_next;
    end
  end

  bprp_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (emit),
    .push_item (push_item),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  // window fill always stays below the cell count
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill < FILL_W'(PATTERN_MAX))
    else $error("window fill reached the cell count");

  // pending drains never exceed the bytes held
  a_drain_fill: assert property (@(posedge clk) disable iff (rst)
    busy |-> (drain <= fill))
    else $error("drain count exceeds window fill");

  // the final byte of a buffer leaves an empty, idle window
  a_last_empty: assert property (@(posedge clk) disable iff (rst)
    (emit && push_item.out_last) |=> ((fill == '0) && !busy))
    else $error("window not empty after final byte");

  // no byte is pushed into a full output buffer
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    emit |-> !buf_full)
    else $error("push into full output buffer");
`endif

endmodule

[rtl/bprp_cell.sv]
// ----------------------------------------------------------------------------
// bprp_cell: one position of the search window
// Holds a byte with its locked and start flags, compares it against its
// pattern byte, rewrites it on a match and shifts toward the window head.
// ----------------------------------------------------------------------------
module bprp_cell
  import bprp_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  input  cell_t      up,
  output cell_t      entry,
  output logic       ok
);

  cell_t held;
  cell_t appended;
  pos_t  my_pos;
  pos_t  k;
  logic  in_win;

  assign my_pos = pos_t'(IDX);

  // incoming byte lands at the current fill position
  always_comb begin
    if (ctrl.append && (ctrl.fill == my_pos)) begin
      appended.data_byte = ctrl.new_byte;
      appended.locked    = 1'b0;
      appended.start     = 1'b0;
    end else begin
      appended = held;
    end
  end

  // position inside the compare window
  assign k      = my_pos - ctrl.base;
  assign in_win = (my_pos >= ctrl.base) && (k < ctrl.len);

  assign ok = !in_win ||
              (!appended.locked &&
               (appended.data_byte == pat_byte(ctrl.old_pattern, k[2:0])));

  // rewrite with replacement or pad on a match
  always_comb begin
    if (ctrl.hit && in_win) begin
      entry.data_byte = (k < ctrl.new_len) ? pat_byte(ctrl.new_pattern, k[2:0])
                                           : ctrl.pad;
      entry.locked    = 1'b1;
      entry.start     = (k == '0);
    end else begin
      entry = appended;
    end
  end

  // shift toward the head on every emitted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
    end else if (ctrl.shift) begin
      held <= up;
    end else if (ctrl.append) begin
      held <= entry;
    end
  end

endmodule

[rtl/bprp_out_buf.sv]
// ----------------------------------------------------------------------------
// bprp_out_buf: two-entry output buffer
// Separates the window from the downstream stall so input keeps flowing
// while one result waits.
// ----------------------------------------------------------------------------
module bprp_out_buf
  import bprp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  out_item_t push_item,
  output logic      full,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic [1:0] cnt;
  logic [1:0] cnt_next;
  out_item_t  head;
  out_item_t  head_next;
  out_item_t  tail;
  out_item_t  tail_next;
  logic       pop;

  assign out_valid = (cnt != 2'd0);
  assign out_data  = head;
  assign full      = (cnt == 2'd2);
  assign pop       = out_valid && !out_stall;

  // entry bookkeeping
  always_comb begin
    cnt_next  = cnt;
    head_next = head;
    tail_next = tail;
    case ({push, pop})
      2'b10: begin
        if (cnt == 2'd0) begin
          head_next = push_item;
        end else begin
          tail_next = push_item;
        end
        cnt_next = cnt + 2'd1;
      end
      2'b01: begin
        head_next = tail;
        cnt_next  = cnt - 2'd1;
      end
      2'b11: begin
        head_next = (cnt == 2'd1) ? push_item : tail;
        tail_next = push_item;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    head <= head_next;
    tail <= tail_next;
  end

endmodule
